// ===== rtl/core/rbc_pkg.sv =====
// shared types, codes and widths of the reorder buffer commit block
`timescale 1ns / 1ps
package rbc_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int RETIRE_WIDTH_DEF = 4;
	localparam int ARCH_REGS_DEF = 32;
	localparam int PHYS_REGS_DEF = 64;

	localparam int OP_W = 3;
	localparam int SLOT_W = 4;
	localparam int EKIND_W = 3;
	localparam int AREG_W = 5;
	localparam int PREG_W = 6;
	localparam int STAMP_W = 32;
	localparam int KIND_W = 3;
	localparam int IN_DATA_W = 96;
	localparam int OUT_DATA_W = 24;

	// raw operation codes on the input tuser
	localparam logic [OP_W-1:0] OPC_ALLOC = 3'd0;
	localparam logic [OP_W-1:0] OPC_READY = 3'd1;
	localparam logic [OP_W-1:0] OPC_SPEC = 3'd2;
	localparam logic [OP_W-1:0] OPC_COMMIT = 3'd3;
	localparam logic [OP_W-1:0] OPC_CLEAR = 3'd4;

	// entry type codes
	localparam logic [EKIND_W-1:0] ET_REG = 3'd0;
	localparam logic [EKIND_W-1:0] ET_LOAD = 3'd1;
	localparam logic [EKIND_W-1:0] ET_STORE = 3'd2;
	localparam logic [EKIND_W-1:0] ET_CBR = 3'd3;
	localparam logic [EKIND_W-1:0] ET_UBR = 3'd4;

	// result kind codes
	localparam logic [KIND_W-1:0] RK_ALLOC = 3'd0;
	localparam logic [KIND_W-1:0] RK_FREE = 3'd1;
	localparam logic [KIND_W-1:0] RK_UPDATE = 3'd2;
	localparam logic [KIND_W-1:0] RK_DROPLD = 3'd3;
	localparam logic [KIND_W-1:0] RK_STORE = 3'd4;
	localparam logic [KIND_W-1:0] RK_RESTORE = 3'd5;
	localparam logic [KIND_W-1:0] RK_DONE = 3'd6;
	localparam logic [KIND_W-1:0] RK_ERROR = 3'd7;

	typedef enum logic [2:0] {
		CL_ALLOC,
		CL_READY,
		CL_SPEC,
		CL_COMMIT,
		CL_CLEAR,
		CL_BAD
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic [SLOT_W-1:0] index;
		logic [EKIND_W-1:0] ekind;
		logic [AREG_W-1:0] arch_reg;
		logic [PREG_W-1:0] new_preg;
		logic [PREG_W-1:0] old_preg;
		logic [STAMP_W-1:0] timestamp;
		logic mispredicted;
		logic [STAMP_W-1:0] flush_limit;
	} item_t;

endpackage

// ===== rtl/core/reorder_buffer_commit.sv =====
// top level of the reorder buffer commit block
`timescale 1ns / 1ps
// Circular reorder buffer driven by one operation word at a time: allocate, set ready,
// set speculation result, commit cycle or clear all. Each word yields one or more result
// words on the master side, the final one marked by tlast; status fields on every result
// word of an operation carry the state after that operation. Allocate, set ready, clear
// and bad operations pass the input queue and execute in the idle state; set speculation
// adds a state for its entry read. A commit examines each retired entry in the head
// state (which also records its first side effect), uses the free and update states for
// each further free alias or update map, and runs a flush through the flush start state,
// a flush loop over the entries freed after the mispredicting head (entered when the
// boundary is not zero) and the flush end state, which records the restore; a closing
// check ends it. Result words are held until m_tready takes them. The flush walk over
// consecutive head entries through the registered entry memory read is what sets the
// length of a long commit. A two-word input queue takes new words while results stream.
module reorder_buffer_commit #(
	parameter int DEPTH = rbc_pkg::DEPTH_DEF,
	parameter int RETIRE_WIDTH = rbc_pkg::RETIRE_WIDTH_DEF,
	parameter int ARCH_REGS = rbc_pkg::ARCH_REGS_DEF,
	parameter int PHYS_REGS = rbc_pkg::PHYS_REGS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// index, entry_kind, arch_reg, new_preg, old_preg, timestamp, mispredicted,
	// flush_limit, zero pad
	input  logic [rbc_pkg::IN_DATA_W-1:0] s_tdata,
	// op
	input  logic [rbc_pkg::OP_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// slot, reg_id, phys_reg, head_advanced, was_flushed, is_empty, is_full, zero pad
	output logic [rbc_pkg::OUT_DATA_W-1:0] m_tdata,
	// kind
	output logic [rbc_pkg::KIND_W-1:0] m_tuser,
	output logic m_tlast
);
	import rbc_pkg::*;

	logic q_valid;
	logic q_pop;
	item_t q_item;

	// front end queue
	rbc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_item(q_item)
	);

	// execution and result stream
	rbc_exec #(
		.DEPTH(DEPTH),
		.RETIRE_WIDTH(RETIRE_WIDTH),
		.ARCH_REGS(ARCH_REGS),
		.PHYS_REGS(PHYS_REGS)
	) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_item(q_item),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

// ===== rtl/core/rbc_front.sv =====
// front end: input word unpacking, operation classification and a two-word queue
`timescale 1ns / 1ps
module rbc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [rbc_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [rbc_pkg::OP_W-1:0] s_tuser,
	output logic q_valid,
	input  logic q_pop,
	output rbc_pkg::item_t q_item
);
	import rbc_pkg::*;

	item_t in_item;
	item_t buf_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic push;

	// classify and unpack the incoming word
	always_comb begin
		case (s_tuser)
			OPC_ALLOC: in_item.cls = CL_ALLOC;
			OPC_READY: in_item.cls = CL_READY;
			OPC_SPEC: in_item.cls = CL_SPEC;
			OPC_COMMIT: in_item.cls = CL_COMMIT;
			OPC_CLEAR: in_item.cls = CL_CLEAR;
			default: in_item.cls = CL_BAD;
		endcase
		in_item.index = s_tdata[3:0];
		in_item.ekind = s_tdata[6:4];
		in_item.arch_reg = s_tdata[11:7];
		in_item.new_preg = s_tdata[17:12];
		in_item.old_preg = s_tdata[23:18];
		in_item.timestamp = s_tdata[55:24];
		in_item.mispredicted = s_tdata[56];
		in_item.flush_limit = s_tdata[88:57];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = buf_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== rtl/core/rbc_exec.sv =====
// back end: entry storage, commit sequencer, result list and output stream
`timescale 1ns / 1ps
module rbc_exec #(
	parameter int DEPTH = rbc_pkg::DEPTH_DEF,
	parameter int RETIRE_WIDTH = rbc_pkg::RETIRE_WIDTH_DEF,
	parameter int ARCH_REGS = rbc_pkg::ARCH_REGS_DEF,
	parameter int PHYS_REGS = rbc_pkg::PHYS_REGS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  rbc_pkg::item_t q_item,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [rbc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [rbc_pkg::KIND_W-1:0] m_tuser,
	output logic m_tlast
);
	import rbc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FCW = $clog2(DEPTH + 1);
	localparam int RCW = $clog2(RETIRE_WIDTH + 1);
	localparam int NRES = 3 * RETIRE_WIDTH + 1;
	localparam int IW = $clog2(NRES);
	localparam int CW = $clog2(NRES + 1);

	typedef struct packed {
		logic [EKIND_W-1:0] etype;
		logic [AREG_W-1:0] arch;
		logic [PREG_W-1:0] nphys;
		logic [PREG_W-1:0] ophys;
		logic [STAMP_W-1:0] stamp;
	} ent_a_t;

	typedef struct packed {
		logic misp;
		logic [STAMP_W-1:0] limit;
	} ent_b_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPEC,
		S_HEAD,
		S_FREE,
		S_UPD,
		S_FSTART,
		S_FLOOP,
		S_FEND,
		S_EMIT
	} state_t;

	state_t state_q;
	item_t cur_q;

	ent_a_t mem_a [DEPTH];
	ent_b_t mem_b [DEPTH];
	ent_a_t rd_a_q;
	ent_b_t rd_b_q;
	logic [PW-1:0] rd_addr;
	logic we_a;
	logic we_b;
	logic [PW-1:0] addr_b;
	ent_a_t wd_a;
	ent_b_t wd_b;

	logic [DEPTH-1:0] valid_q;
	logic [DEPTH-1:0] ready_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] head_nxt;
	logic moved_q;
	logic flush_q;

	logic [RCW-1:0] ret_q;
	logic [FCW-1:0] fcnt_q;
	logic [PW-1:0] fslot_q;
	logic [STAMP_W-1:0] first_q;
	logic [STAMP_W-1:0] flim_q;
	logic fbr_q;

	logic [KIND_W-1:0] rk_q [NRES];
	logic [SLOT_W-1:0] rs_q [NRES];
	logic [AREG_W-1:0] rr_q [NRES];
	logic [PREG_W-1:0] rp_q [NRES];
	logic [CW-1:0] n_q;
	logic [IW-1:0] o_q;

	logic push;
	logic [KIND_W-1:0] p_kind;
	logic [SLOT_W-1:0] p_slot;
	logic [AREG_W-1:0] p_reg;
	logic [PREG_W-1:0] p_phys;
	logic free_now;
	logic take;
	logic [PW-1:0] idx_p;
	logic idx_ok;
	logic alloc_ok;
	logic is_full;
	logic is_empty;
	logic head_live;
	logic in_range;
	logic spec_kind_ok;
	logic out_last;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign take = (state_q == S_IDLE) && q_valid;
	assign q_pop = take;
	assign idx_p = PW'(q_item.index);
	assign idx_ok = (int'(q_item.index) < DEPTH) && valid_q[idx_p];
	assign is_empty = (head_q == tail_q);
	assign is_full = (ptr_inc(tail_q) == head_q);
	assign alloc_ok = !is_full && (q_item.ekind <= ET_UBR)
		&& (int'(q_item.arch_reg) < ARCH_REGS)
		&& (int'(q_item.new_preg) < PHYS_REGS)
		&& (int'(q_item.old_preg) < PHYS_REGS);
	assign head_live = valid_q[head_q] && ready_q[head_q];
	assign in_range = (rd_a_q.stamp >= first_q) && (rd_a_q.stamp <= flim_q);
	assign spec_kind_ok = (rd_a_q.etype == ET_LOAD) || (rd_a_q.etype == ET_CBR)
		|| (rd_a_q.etype == ET_UBR);

	// per-state result push and head release
	always_comb begin
		push = 1'b0;
		p_kind = RK_DONE;
		p_slot = '0;
		p_reg = '0;
		p_phys = '0;
		free_now = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_item.cls)
						CL_ALLOC: begin
							push = 1'b1;
							p_kind = alloc_ok ? RK_ALLOC : RK_ERROR;
							p_slot = SLOT_W'(tail_q);
						end
						CL_READY: begin
							push = 1'b1;
							p_kind = idx_ok ? RK_DONE : RK_ERROR;
							p_slot = q_item.index;
						end
						CL_SPEC: begin
							if (!idx_ok) begin
								push = 1'b1;
								p_kind = RK_ERROR;
								p_slot = q_item.index;
							end
						end
						CL_CLEAR: begin
							push = 1'b1;
							p_kind = RK_DONE;
						end
						CL_BAD: begin
							push = 1'b1;
							p_kind = RK_ERROR;
						end
						default: ;
					endcase
				end
			end
			S_SPEC: begin
				push = 1'b1;
				p_kind = spec_kind_ok ? RK_DONE : RK_ERROR;
				p_slot = cur_q.index;
			end
			S_HEAD: begin
				if ((int'(ret_q) == RETIRE_WIDTH) || !head_live) begin
					push = 1'b1;
					p_kind = RK_DONE;
					p_slot = SLOT_W'(head_q);
				end else begin
					case (rd_a_q.etype)
						ET_LOAD: begin
							push = 1'b1;
							p_kind = RK_DROPLD;
							p_slot = SLOT_W'(head_q);
						end
						ET_STORE: begin
							push = 1'b1;
							p_kind = RK_STORE;
							p_slot = SLOT_W'(head_q);
							free_now = 1'b1;
						end
						ET_CBR: begin
							free_now = !rd_b_q.misp;
						end
						default: begin
							push = 1'b1;
							p_kind = RK_FREE;
							p_slot = SLOT_W'(head_q);
							p_phys = rd_a_q.ophys;
						end
					endcase
				end
			end
			S_FREE: begin
				push = 1'b1;
				p_kind = RK_FREE;
				p_slot = SLOT_W'(head_q);
				p_phys = rd_a_q.ophys;
			end
			S_UPD: begin
				push = 1'b1;
				p_kind = RK_UPDATE;
				p_slot = SLOT_W'(head_q);
				p_reg = rd_a_q.arch;
				p_phys = rd_a_q.nphys;
				free_now = !((rd_a_q.etype == ET_UBR) && rd_b_q.misp);
			end
			S_FSTART: begin
				free_now = 1'b1;
			end
			S_FLOOP: begin
				free_now = (int'(fcnt_q) < DEPTH) && valid_q[head_q] && in_range;
			end
			S_FEND: begin
				push = 1'b1;
				p_kind = RK_RESTORE;
				p_slot = SLOT_W'(fslot_q);
			end
			default: ;
		endcase
	end

	// next head, read address and write controls of the entry memories
	always_comb begin
		head_nxt = free_now ? ptr_inc(head_q) : head_q;
		rd_addr = (take && (q_item.cls == CL_SPEC)) ? idx_p : head_nxt;
		we_a = take && (q_item.cls == CL_ALLOC) && alloc_ok;
		wd_a.etype = q_item.ekind;
		wd_a.arch = q_item.arch_reg;
		wd_a.nphys = q_item.new_preg;
		wd_a.ophys = q_item.old_preg;
		wd_a.stamp = q_item.timestamp;
		we_b = we_a || ((state_q == S_SPEC) && spec_kind_ok);
		addr_b = we_a ? tail_q : PW'(cur_q.index);
		wd_b.misp = we_a ? 1'b0 : cur_q.mispredicted;
		wd_b.limit = we_a ? '0 : cur_q.flush_limit;
	end

	// entry memories, registered read
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[tail_q] <= wd_a;
		end
		if (we_b) begin
			mem_b[addr_b] <= wd_b;
		end
		rd_a_q <= mem_a[rd_addr];
		rd_b_q <= mem_b[rd_addr];
	end

	// result list payload, current operation and flush capture
	always_ff @(posedge clk) begin
		if (push) begin
			rk_q[n_q[IW-1:0]] <= p_kind;
			rs_q[n_q[IW-1:0]] <= p_slot;
			rr_q[n_q[IW-1:0]] <= p_reg;
			rp_q[n_q[IW-1:0]] <= p_phys;
		end
		if (take) begin
			cur_q <= q_item;
		end
		if (state_q == S_FSTART) begin
			fslot_q <= head_q;
			first_q <= rd_a_q.stamp;
			flim_q <= rd_b_q.limit;
			fbr_q <= (rd_a_q.etype != ET_LOAD);
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			ready_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			moved_q <= 1'b0;
			flush_q <= 1'b0;
			ret_q <= '0;
			fcnt_q <= '0;
			n_q <= '0;
			o_q <= '0;
		end else begin
			if (free_now) begin
				head_q <= head_nxt;
				valid_q[head_q] <= 1'b0;
				ready_q[head_q] <= 1'b0;
			end
			if (push) begin
				n_q <= n_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						case (q_item.cls)
							CL_ALLOC: begin
								if (alloc_ok) begin
									valid_q[tail_q] <= 1'b1;
									ready_q[tail_q] <= 1'b0;
									tail_q <= ptr_inc(tail_q);
								end
								state_q <= S_EMIT;
							end
							CL_READY: begin
								if (idx_ok) begin
									ready_q[idx_p] <= 1'b1;
								end
								state_q <= S_EMIT;
							end
							CL_SPEC: begin
								state_q <= idx_ok ? S_SPEC : S_EMIT;
							end
							CL_COMMIT: begin
								moved_q <= 1'b0;
								flush_q <= 1'b0;
								ret_q <= '0;
								state_q <= S_HEAD;
							end
							CL_CLEAR: begin
								valid_q <= '0;
								ready_q <= '0;
								head_q <= '0;
								tail_q <= '0;
								moved_q <= 1'b0;
								flush_q <= 1'b0;
								state_q <= S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SPEC: begin
					if (spec_kind_ok) begin
						ready_q[PW'(cur_q.index)] <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_HEAD: begin
					if ((int'(ret_q) == RETIRE_WIDTH) || !head_live) begin
						state_q <= S_EMIT;
					end else begin
						moved_q <= 1'b1;
						case (rd_a_q.etype)
							ET_LOAD: begin
								state_q <= rd_b_q.misp ? S_FSTART : S_FREE;
							end
							ET_STORE: begin
								ret_q <= ret_q + 1'b1;
							end
							ET_CBR: begin
								if (rd_b_q.misp) begin
									state_q <= S_FSTART;
								end else begin
									ret_q <= ret_q + 1'b1;
								end
							end
							default: begin
								state_q <= S_UPD;
							end
						endcase
					end
				end
				S_FREE: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (free_now) begin
						ret_q <= ret_q + 1'b1;
						state_q <= S_HEAD;
					end else begin
						state_q <= S_FSTART;
					end
				end
				S_FSTART: begin
					fcnt_q <= FCW'(1);
					state_q <= (rd_b_q.limit == '0) ? S_FEND : S_FLOOP;
				end
				S_FLOOP: begin
					if (free_now) begin
						fcnt_q <= fcnt_q + 1'b1;
					end else begin
						state_q <= S_FEND;
					end
				end
				S_FEND: begin
					if (fbr_q) begin
						flush_q <= 1'b1;
					end
					ret_q <= ret_q + 1'b1;
					state_q <= S_HEAD;
				end
				S_EMIT: begin
					if (m_tready) begin
						if (out_last) begin
							n_q <= '0;
							o_q <= '0;
							state_q <= S_IDLE;
						end else begin
							o_q <= o_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result stream
	assign out_last = (CW'(o_q) == (n_q - 1'b1));
	assign m_tvalid = (state_q == S_EMIT);
	assign m_tuser = rk_q[o_q];
	assign m_tlast = out_last;
	assign m_tdata = {5'd0, is_full, is_empty, flush_q, moved_q,
		rp_q[o_q], rr_q[o_q], rs_q[o_q]};

endmodule
